@@ hw/rtl/cvs_pkg.sv @@
// Shared types, widths, codes and helpers for the convex support point pipeline.
`timescale 1ns / 1ps
package cvs_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int ROT_W = 16;
  localparam int RAD_W = 15;
  localparam int CFG_W = 48;
  localparam int REG_IDX_W = 3;

  // Local direction: exact rotation sum, scaled down and rounded.
  localparam int DEN_SH = COORD_WIDTH - 10;
  localparam int ACC_W = ROT_W + COORD_WIDTH + 2;
  localparam int LW = ACC_W - DEN_SH + 1;
  // Sum of squares and its root.
  localparam int SQW = 2 * LW + 2;
  localparam int RW = SQW / 2;
  // Radial quotient never exceeds twice the radius.
  localparam int QW = RAD_W + 2;
  localparam int DIVW = RW + QW + 1;
  // Local point and final transform.
  localparam int VW = QW + 2;
  localparam int PW = ROT_W + VW;
  localparam int OW = PW + 3;

  localparam logic [1:0] SHAPE_SPHERE = 2'd0;
  localparam logic [1:0] SHAPE_CYLINDER = 2'd1;
  localparam logic [1:0] SHAPE_CAPSULE = 2'd2;
  localparam logic [1:0] SHAPE_BOX = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_SHAPE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RADIUS = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BOX = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ROT_A = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ROT_B = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ROT_C = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_TRANS = 3'd7;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [LW-1:0] lcomp_t;
  typedef logic [RW-1:0] sroot_t;
  typedef logic [QW-1:0] qmag_t;

  typedef struct packed {
    logic [1:0]       shape;
    logic [RAD_W-1:0] radius;
    logic [RAD_W-1:0] height;
    logic [CFG_W-1:0] box;
    logic [CFG_W-1:0] rot_a;
    logic [CFG_W-1:0] rot_b;
    logic [CFG_W-1:0] rot_c;
    logic [CFG_W-1:0] trans;
  } cfg_t;

  // Rotation entry R[i][j], signed Q2.14.
  function automatic logic signed [ROT_W-1:0] rot_entry(cfg_t c, int i, int j);
    logic [CFG_W-1:0] row;
    row = (i == 0) ? c.rot_a : ((i == 1) ? c.rot_b : c.rot_c);
    return row[ROT_W*j +: ROT_W];
  endfunction

endpackage

@@ hw/rtl/convex_support_point_core.sv @@
// Top level of the convex support point pipeline with its configuration registers.
`timescale 1ns / 1ps
// Support mapping for a posed sphere, cylinder, capsule or box.
// The input channel (in_valid/in_ready, dir_x/y/z) carries one world direction per
// transaction; the output channel (out_valid/out_ready, point_x/y/z) returns the
// furthest point of the shape along it, one transaction out for each one in, in order.
// The pipeline is 55 register stages long: two for the rotation into the local frame,
// two for the squared length, one per root bit of the square root (30), one for the
// numerators plus one per quotient bit of the radial division (18 together), and three for the
// shape rule, the rotation back and the rounded, saturated output register.
// Throughput is one transaction per cycle while the receiver takes results.
// The whole pipeline advances on one enable: when a result sits in the output register
// and out_ready is low, every stage holds and in_ready is low, so nothing is lost.
// Configuration is written through cfg_wen/cfg_index/cfg_wdata, one register per
// cycle, and must only change while no transaction is in flight.
// Synchronous reset clears all valid bits and sets every configuration register to zero.
module convex_support_point_core import cvs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [COORD_WIDTH-1:0] dir_x,
  input  logic signed [COORD_WIDTH-1:0] dir_y,
  input  logic signed [COORD_WIDTH-1:0] dir_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [COORD_WIDTH-1:0] point_x,
  output logic signed [COORD_WIDTH-1:0] point_y,
  output logic signed [COORD_WIDTH-1:0] point_z
);

  cfg_t cfg;
  logic en;
  coord_t d [3];
  lcomp_t l_rot [3];
  lcomp_t l_sqrt [3];
  lcomp_t l_div [3];
  sroot_t s_sqrt;
  sroot_t s_div;
  qmag_t q_div [3];
  coord_t point [3];
  logic v_rot;
  logic v_sqrt;
  logic v_div;

  // Configuration registers, written by index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_SHAPE:  cfg.shape <= cfg_wdata[1:0];
        REG_RADIUS: cfg.radius <= cfg_wdata[RAD_W-1:0];
        REG_HEIGHT: cfg.height <= cfg_wdata[RAD_W-1:0];
        REG_BOX:    cfg.box <= cfg_wdata;
        REG_ROT_A:  cfg.rot_a <= cfg_wdata;
        REG_ROT_B:  cfg.rot_b <= cfg_wdata;
        REG_ROT_C:  cfg.rot_c <= cfg_wdata;
        REG_TRANS:  cfg.trans <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // All stages move together unless a finished result is waiting to be taken.
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  assign d[0] = dir_x;
  assign d[1] = dir_y;
  assign d[2] = dir_z;

  cvs_rotate u_rotate (
    .clk(clk), .rst(rst), .en(en), .cfg(cfg),
    .in_valid(in_valid), .d(d),
    .out_valid(v_rot), .l(l_rot)
  );

  cvs_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .cfg(cfg),
    .in_valid(v_rot), .l_in(l_rot),
    .out_valid(v_sqrt), .l_out(l_sqrt), .s(s_sqrt)
  );

  cvs_divide u_divide (
    .clk(clk), .rst(rst), .en(en), .cfg(cfg),
    .in_valid(v_sqrt), .l_in(l_sqrt), .s_in(s_sqrt),
    .out_valid(v_div), .l_out(l_div), .s_out(s_div), .q(q_div)
  );

  cvs_transform u_transform (
    .clk(clk), .rst(rst), .en(en), .cfg(cfg),
    .in_valid(v_div), .l(l_div), .s(s_div), .q(q_div),
    .out_valid(out_valid), .point(point)
  );

  assign point_x = point[0];
  assign point_y = point[1];
  assign point_z = point[2];

endmodule

@@ hw/rtl/cvs_rotate.sv @@
// Rotation of the world direction into the local frame, two stages.
`timescale 1ns / 1ps
module cvs_rotate import cvs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  cfg_t   cfg,
  input  logic   in_valid,
  input  coord_t d [3],
  output logic   out_valid,
  output lcomp_t l [3]
);

  typedef logic signed [ROT_W+COORD_WIDTH-1:0] prod_t;

  prod_t prod [3][3];
  logic v1;
  logic signed [ACC_W-1:0] acc [3];
  logic [ACC_W:0] mag [3];
  logic [ACC_W:0] q [3];
  lcomp_t l_next [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc[j] = ACC_W'(prod[0][j]) + ACC_W'(prod[1][j]) + ACC_W'(prod[2][j]);
      mag[j] = acc[j][ACC_W-1] ? ((ACC_W+1)'(0) - (ACC_W+1)'(acc[j]))
                               : (ACC_W+1)'(acc[j]);
      q[j] = (mag[j] + ((ACC_W+1)'(1) << (DEN_SH - 1))) >> DEN_SH;
      l_next[j] = acc[j][ACC_W-1] ? LW'(~q[j] + 1'b1) : LW'(q[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= rot_entry(cfg, i, j) * d[i];
        end
      end
      for (int j = 0; j < 3; j++) begin
        l[j] <= l_next[j];
      end
    end
  end

endmodule

@@ hw/rtl/cvs_sqrt.sv @@
// Squared length of the local direction (x and y only for a cylinder) and a one-bit-per-stage integer square root.
`timescale 1ns / 1ps
module cvs_sqrt import cvs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  cfg_t   cfg,
  input  logic   in_valid,
  input  lcomp_t l_in [3],
  output logic   out_valid,
  output lcomp_t l_out [3],
  output sroot_t s
);

  logic [2*LW-1:0] sq [3];
  logic [SQW-1:0] x [RW+1];
  logic [SQW-1:0] r [RW+1];
  logic [SQW-1:0] xn [RW];
  logic [SQW-1:0] rn [RW];
  logic [SQW-1:0] trial [RW];
  lcomp_t lp [RW+2][3];
  logic [RW+1:0] vp;

  always_comb begin
    for (int k = 0; k < RW; k++) begin
      trial[k] = r[k] + (SQW'(1) << (2 * (RW - 1 - k)));
      if (x[k] >= trial[k]) begin
        xn[k] = x[k] - trial[k];
        rn[k] = (r[k] >> 1) + (SQW'(1) << (2 * (RW - 1 - k)));
      end else begin
        xn[k] = x[k];
        rn[k] = r[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (en) begin
      vp <= {vp[RW:0], in_valid};
    end
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        // The cylinder takes its radial length over x and y only.
        if (j == 2 && cfg.shape == SHAPE_CYLINDER) begin
          sq[j] <= '0;
        end else begin
          sq[j] <= (2*LW)'(l_in[j] * l_in[j]);
        end
        lp[0][j] <= l_in[j];
      end
      x[0] <= SQW'(sq[0]) + SQW'(sq[1]) + SQW'(sq[2]);
      r[0] <= '0;
      for (int j = 0; j < 3; j++) begin
        lp[1][j] <= lp[0][j];
      end
      for (int k = 0; k < RW; k++) begin
        x[k+1] <= xn[k];
        r[k+1] <= rn[k];
        for (int j = 0; j < 3; j++) begin
          lp[k+2][j] <= lp[k+1][j];
        end
      end
    end
  end

  assign out_valid = vp[RW+1];
  assign s = r[RW][RW-1:0];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      l_out[j] = lp[RW+1][j];
    end
  end

endmodule

@@ hw/rtl/cvs_divide.sv @@
// Radial scaling: three lanes of rounded restoring division, one quotient bit per stage.
`timescale 1ns / 1ps
module cvs_divide import cvs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  cfg_t   cfg,
  input  logic   in_valid,
  input  lcomp_t l_in [3],
  input  sroot_t s_in,
  output logic   out_valid,
  output lcomp_t l_out [3],
  output sroot_t s_out,
  output qmag_t  q [3]
);

  logic [DIVW-1:0] nrem [QW+1][3];
  qmag_t qacc [QW+1][3];
  lcomp_t lp [QW+1][3];
  sroot_t sp [QW+1];
  logic [QW:0] vp;
  logic [DIVW-1:0] dsh [QW];
  logic [DIVW-1:0] nn [QW][3];
  qmag_t qn [QW][3];
  logic [LW-1:0] lmag [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      lmag[j] = l_in[j][LW-1] ? LW'(-l_in[j]) : LW'(l_in[j]);
    end
    for (int k = 0; k < QW; k++) begin
      dsh[k] = DIVW'(sp[k]) << (QW - 1 - k);
      for (int j = 0; j < 3; j++) begin
        if (nrem[k][j] >= dsh[k]) begin
          nn[k][j] = nrem[k][j] - dsh[k];
          qn[k][j] = qacc[k][j] | (QW'(1) << (QW - 1 - k));
        end else begin
          nn[k][j] = nrem[k][j];
          qn[k][j] = qacc[k][j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (en) begin
      vp <= {vp[QW-1:0], in_valid};
    end
    if (en) begin
      // Numerator 2*radius*|l| plus half the divisor gives round half away from zero.
      for (int j = 0; j < 3; j++) begin
        nrem[0][j] <= DIVW'(lmag[j] * {cfg.radius, 1'b0}) + DIVW'(s_in >> 1);
        qacc[0][j] <= '0;
        lp[0][j] <= l_in[j];
      end
      sp[0] <= s_in;
      for (int k = 0; k < QW; k++) begin
        sp[k+1] <= sp[k];
        for (int j = 0; j < 3; j++) begin
          nrem[k+1][j] <= nn[k][j];
          qacc[k+1][j] <= qn[k][j];
          lp[k+1][j] <= lp[k][j];
        end
      end
    end
  end

  assign out_valid = vp[QW];
  assign s_out = sp[QW];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      l_out[j] = lp[QW][j];
      q[j] = qacc[QW][j];
    end
  end

endmodule

@@ hw/rtl/cvs_transform.sv @@
// Shape rule, rotation back to world frame, translation, rounding and saturation.
`timescale 1ns / 1ps
module cvs_transform import cvs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  cfg_t   cfg,
  input  logic   in_valid,
  input  lcomp_t l [3],
  input  sroot_t s,
  input  qmag_t  q [3],
  output logic   out_valid,
  output coord_t point [3]
);

  typedef logic signed [VW-1:0] vcomp_t;

  localparam logic signed [OW-1:0] HI = OW'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
  localparam logic signed [OW-1:0] LO = -HI - OW'(1);

  vcomp_t rv [3];
  vcomp_t v_next [3];
  vcomp_t v [3];
  logic signed [PW-1:0] prod [3][3];
  logic signed [OW-1:0] acc [3];
  logic [OW-1:0] mag [3];
  logic [OW-1:0] rq [3];
  logic signed [OW-1:0] p [3];
  coord_t p_sat [3];
  vcomp_t hgt;
  vcomp_t sz [3];
  logic [1:0] vp;

  always_comb begin
    hgt = VW'(cfg.height);
    for (int j = 0; j < 3; j++) begin
      sz[j] = VW'(cfg.box[16*j +: 16]);
      rv[j] = l[j][LW-1] ? -VW'(q[j]) : VW'(q[j]);
    end
    // A direction that rounds to zero falls back to the local x axis.
    if (s == '0) begin
      rv[0] = VW'({cfg.radius, 1'b0});
      rv[1] = '0;
      rv[2] = '0;
    end
    for (int j = 0; j < 3; j++) begin
      v_next[j] = rv[j];
    end
    case (cfg.shape)
      SHAPE_SPHERE: begin
      end
      SHAPE_CYLINDER: begin
        v_next[2] = l[2][LW-1] ? -hgt : hgt;
      end
      SHAPE_CAPSULE: begin
        v_next[2] = rv[2] + ((!l[2][LW-1] && l[2] != '0) ? hgt : -hgt);
      end
      default: begin
        for (int j = 0; j < 3; j++) begin
          v_next[j] = l[j][LW-1] ? -sz[j] : sz[j];
        end
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = (OW'(signed'(cfg.trans[16*i +: 16])) <<< 15)
             + OW'(prod[i][0]) + OW'(prod[i][1]) + OW'(prod[i][2]);
      mag[i] = acc[i][OW-1] ? OW'(-acc[i]) : OW'(acc[i]);
      rq[i] = (mag[i] + (OW'(1) << 14)) >> 15;
      p[i] = acc[i][OW-1] ? -signed'(rq[i]) : signed'(rq[i]);
      if (p[i] > HI) begin
        p_sat[i] = COORD_WIDTH'(HI);
      end else if (p[i] < LO) begin
        p_sat[i] = COORD_WIDTH'(LO);
      end else begin
        p_sat[i] = COORD_WIDTH'(p[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vp <= {vp[0], in_valid};
      out_valid <= vp[1];
    end
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        v[j] <= v_next[j];
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= rot_entry(cfg, i, j) * v[j];
        end
        point[i] <= p_sat[i];
      end
    end
  end

endmodule

@@ hw/rtl/cvs_checker.sv @@
// Port-level checks for the convex support point core, bound to the top level.
`timescale 1ns / 1ps
module cvs_checker import cvs_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [COORD_WIDTH-1:0] point_x,
  input logic signed [COORD_WIDTH-1:0] point_y,
  input logic signed [COORD_WIDTH-1:0] point_z
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result presented right after reset");

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y)
      && $stable(point_z))
    else $error("stalled result changed or vanished");

  // A stalled output freezes the whole pipeline, so no new transaction is taken.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // With the output free the pipeline always takes new work.
  a_free_accepts: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input refused while pipeline can advance");

endmodule

bind convex_support_point_core cvs_checker u_cvs_checker (.*);
